/* rtl/wavhp_pkg.sv */
// Shared types and constants for the WAV header parser and PCM frame streamer.
// No dependencies; imported by wav_header_parser_pcm_stream.
`default_nettype none

package wavhp_pkg;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 32;
  localparam int unsigned OutDataWidth  = 40;

  // Configuration register indexes
  localparam logic [CfgIndexWidth-1:0] CFG_SAMPLE_RATE = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_SAMPLE_BITS = 2'd1;

  localparam logic [31:0] RESET_SAMPLE_RATE = 32'd16000;
  localparam logic [15:0] RESET_SAMPLE_BITS = 16'd16;

  // Chunk identifiers, first character in the lowest byte
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_BODY_BYTES = 32'd16;
  localparam logic [15:0] FORMAT_PCM     = 16'd1;

  typedef enum logic [2:0] {
    STATUS_OK         = 3'd0,
    STATUS_NOT_WAVE   = 3'd1,
    STATUS_FMT_SMALL  = 3'd2,
    STATUS_FMT_MISSING = 3'd3,
    STATUS_UNSUPPORTED = 3'd4,
    STATUS_ZERO_ALIGN = 3'd5
  } status_t;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_FRAME  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    status_t     code;
    logic [15:0] left;
    logic [15:0] right;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

/* rtl/wav_header_parser_pcm_stream.sv */
// WAV header parser and PCM frame streamer, top level.
// Depends on wavhp_pkg for tags, status codes and the result record.
//
// Usage: the file arrives one byte per item on the s_axis channel, with
// tuser high on the first byte of each file, which restarts the parser.
// The RIFF/WAVE header and the chunk list are walked in place; a bad header,
// a short fmt chunk or a completed data chunk header sends one status item
// (tuser low) on m_axis, and for a good format every following full frame of
// the data chunk is sent as a stereo item (tuser high), mono samples copied to
// both channels, with tlast on the final frame. A trailing partial frame is
// dropped. An output register and a skid register sit behind the parser, so
// bytes keep flowing while one result waits; s_axis_tready falls only while
// both hold, and else one byte is taken every cycle. Each result is registered
// into the output register, or into the skid register while the output waits.
// The configuration port writes the required rate (index 0) and sample bits
// (index 1); the user writes while the stream is quiet, unchecked by the block.
// Reset returns the parser to idle, empties the output and restores 16000 Hz and 16 bits.
`default_nettype none

module wav_header_parser_pcm_stream (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [wavhp_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  wire logic [wavhp_pkg::CfgDataWidth-1:0]    cfg_data,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  wire logic [7:0]                            s_axis_tdata,  // file_byte
  input  wire logic                                  s_axis_tuser,  // file_start
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // status_code [2:0], left_sample [18:3], right_sample [34:19], zero [39:35]
  output logic [wavhp_pkg::OutDataWidth-1:0]         m_axis_tdata,
  output logic                                       m_axis_tuser,  // result_kind
  output logic                                       m_axis_tlast   // last_frame
);
  import wavhp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RIFF,
    PH_CHUNK,
    PH_FMT,
    PH_SKIP,
    PH_DATA,
    PH_TAIL
  } phase_t;

  logic [31:0] req_rate;
  logic [15:0] req_bits;

  phase_t      phase, phase_next;
  logic [4:0]  pos, pos_next;
  logic [31:0] tag, tag_next;
  logic [31:0] len, len_next;
  logic [31:0] skip, skip_next;
  logic        pad, pad_next;
  logic [15:0] fmt_tag, fmt_tag_next;
  logic [15:0] chans, chans_next;
  logic [31:0] rate, rate_next;
  logic [15:0] bits, bits_next;
  logic [15:0] align, align_next;
  logic        fmt_seen, fmt_seen_next;
  logic [31:0] data_rem, data_rem_next;
  // Upper three bytes of the sample shift register; the fourth is the byte in hand.
  logic [23:0] asm_bytes, asm_bytes_next;

  logic        accept;
  logic        res_valid;
  result_t     res;

  logic        out_valid;
  result_t     out_res;
  logic        skid_valid;
  result_t     skid_res;

  function automatic status_t check_format(
    input logic        seen,
    input logic [15:0] ftag,
    input logic [15:0] fbits,
    input logic [31:0] frate,
    input logic [15:0] fchans,
    input logic [15:0] falign,
    input logic [15:0] rbits,
    input logic [31:0] rrate
  );
    status_t code;
    if (!seen) begin
      code = STATUS_FMT_MISSING;
    end else if (ftag != FORMAT_PCM || fbits != rbits || frate != rrate ||
                 (fchans != 16'd1 && fchans != 16'd2)) begin
      code = STATUS_UNSUPPORTED;
    end else if (falign == 16'd0) begin
      code = STATUS_ZERO_ALIGN;
    end else begin
      code = STATUS_OK;
    end
    return code;
  endfunction

  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    logic [7:0]  b;
    logic [31:0] frame_bytes;
    logic [31:0] shifted;
    status_t     code;
    b              = s_axis_tdata;
    frame_bytes    = (chans == 16'd1) ? 32'd2 : 32'd4;
    shifted        = '0;
    code           = STATUS_OK;
    phase_next     = phase;
    pos_next       = pos;
    tag_next       = tag;
    len_next       = len;
    skip_next      = skip;
    pad_next       = pad;
    fmt_tag_next   = fmt_tag;
    chans_next     = chans;
    rate_next      = rate;
    bits_next      = bits;
    align_next     = align;
    fmt_seen_next  = fmt_seen;
    data_rem_next  = data_rem;
    asm_bytes_next = asm_bytes;
    res_valid      = 1'b0;
    res            = '{kind: KIND_STATUS, code: STATUS_OK, left: '0, right: '0, last: 1'b0};

    if (accept) begin
      if (s_axis_tuser) begin
        phase_next     = PH_RIFF;
        pos_next       = '0;
        tag_next       = '0;
        len_next       = '0;
        skip_next      = '0;
        pad_next       = 1'b0;
        fmt_tag_next   = '0;
        chans_next     = '0;
        rate_next      = '0;
        bits_next      = '0;
        align_next     = '0;
        fmt_seen_next  = 1'b0;
        data_rem_next  = '0;
        asm_bytes_next = '0;
        frame_bytes    = 32'd4;
      end

      case (phase_next)
        PH_RIFF: begin
          tag_next = {b, tag_next[31:8]};
          pos_next = pos_next + 5'd1;
          if (pos_next == 5'd4) begin
            len_next = tag_next;
          end
          if (pos_next >= 5'd12) begin
            pos_next = '0;
            if (len_next == TAG_RIFF && tag_next == TAG_WAVE) begin
              phase_next = PH_CHUNK;
            end else begin
              phase_next = PH_IDLE;
              res_valid  = 1'b1;
              res.code   = STATUS_NOT_WAVE;
            end
            tag_next = '0;
            len_next = '0;
          end
        end

        PH_CHUNK: begin
          if (pos_next < 5'd4) begin
            tag_next = {b, tag_next[31:8]};
          end else begin
            len_next = {b, len_next[31:8]};
          end
          pos_next = pos_next + 5'd1;
          if (pos_next >= 5'd8) begin
            pos_next = '0;
            pad_next = len_next[0];
            if (tag_next == TAG_FMT) begin
              if (len_next < FMT_BODY_BYTES) begin
                phase_next = PH_IDLE;
                res_valid  = 1'b1;
                res.code   = STATUS_FMT_SMALL;
              end else begin
                skip_next  = len_next - FMT_BODY_BYTES;
                phase_next = PH_FMT;
              end
            end else if (tag_next == TAG_DATA) begin
              code = check_format(fmt_seen_next, fmt_tag_next, bits_next, rate_next,
                                  chans_next, align_next, req_bits, req_rate);
              pad_next       = 1'b0;
              asm_bytes_next = '0;
              res_valid      = 1'b1;
              res.code       = code;
              if (code != STATUS_OK) begin
                phase_next = PH_IDLE;
              end else begin
                data_rem_next = len_next;
                if (len_next == 32'd0) begin
                  phase_next = PH_IDLE;
                end else if (len_next < frame_bytes) begin
                  phase_next = PH_TAIL;
                end else begin
                  phase_next = PH_DATA;
                end
              end
            end else begin
              skip_next  = len_next;
              phase_next = (len_next == 32'd0) ? PH_CHUNK : PH_SKIP;
            end
          end
        end

        PH_FMT: begin
          case (pos_next)
            5'd0:    fmt_tag_next = {8'd0, b};
            5'd1:    fmt_tag_next = {b, fmt_tag_next[7:0]};
            5'd2:    chans_next = {8'd0, b};
            5'd3:    chans_next = {b, chans_next[7:0]};
            5'd4:    rate_next = {24'd0, b};
            5'd5:    rate_next = {16'd0, b, rate_next[7:0]};
            5'd6:    rate_next = {8'd0, b, rate_next[15:0]};
            5'd7:    rate_next = {b, rate_next[23:0]};
            5'd12:   align_next = {8'd0, b};
            5'd13:   align_next = {b, align_next[7:0]};
            5'd14:   bits_next = {8'd0, b};
            5'd15:   bits_next = {b, bits_next[7:0]};
            default: ;
          endcase
          pos_next = pos_next + 5'd1;
          if (pos_next >= 5'(FMT_BODY_BYTES)) begin
            fmt_seen_next = 1'b1;
            pos_next      = '0;
            phase_next    = (skip_next == 32'd0 && !pad_next) ? PH_CHUNK : PH_SKIP;
          end
        end

        PH_SKIP: begin
          if (skip_next != 32'd0) begin
            skip_next = skip_next - 32'd1;
          end else begin
            pad_next = 1'b0;
          end
          if (skip_next == 32'd0 && !pad_next) begin
            pos_next   = '0;
            phase_next = PH_CHUNK;
          end
        end

        PH_DATA: begin
          shifted        = {b, asm_bytes_next};
          asm_bytes_next = shifted[31:8];
          if (data_rem_next != 32'd0) begin
            data_rem_next = data_rem_next - 32'd1;
          end
          pos_next = pos_next + 5'd1;
          if (32'(pos_next) >= frame_bytes) begin
            res_valid = 1'b1;
            res.kind  = KIND_FRAME;
            res.last  = data_rem_next < frame_bytes;
            if (chans_next == 16'd1) begin
              res.left  = shifted[31:16];
              res.right = shifted[31:16];
            end else begin
              res.left  = shifted[15:0];
              res.right = shifted[31:16];
            end
            pos_next       = '0;
            asm_bytes_next = '0;
            if (res.last) begin
              phase_next = (data_rem_next == 32'd0) ? PH_IDLE : PH_TAIL;
            end
          end
        end

        PH_TAIL: begin
          if (data_rem_next != 32'd0) begin
            data_rem_next = data_rem_next - 32'd1;
          end
          if (data_rem_next == 32'd0) begin
            phase_next = PH_IDLE;
          end
        end

        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_rate   <= RESET_SAMPLE_RATE;
      req_bits   <= RESET_SAMPLE_BITS;
      phase      <= PH_IDLE;
      pos        <= '0;
      tag        <= '0;
      len        <= '0;
      skip       <= '0;
      pad        <= 1'b0;
      fmt_tag    <= '0;
      chans      <= '0;
      rate       <= '0;
      bits       <= '0;
      align      <= '0;
      fmt_seen   <= 1'b0;
      data_rem   <= '0;
      asm_bytes  <= '0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SAMPLE_RATE: req_rate <= cfg_data;
          CFG_SAMPLE_BITS: req_bits <= cfg_data[15:0];
          default: ;
        endcase
      end

      phase     <= phase_next;
      pos       <= pos_next;
      tag       <= tag_next;
      len       <= len_next;
      skip      <= skip_next;
      pad       <= pad_next;
      fmt_tag   <= fmt_tag_next;
      chans     <= chans_next;
      rate      <= rate_next;
      bits      <= bits_next;
      align     <= align_next;
      fmt_seen  <= fmt_seen_next;
      data_rem  <= data_rem_next;
      asm_bytes <= asm_bytes_next;

      // A new result can only arrive while the skid register is empty.
      if (!out_valid || m_axis_tready) begin
        if (skid_valid) begin
          out_res    <= skid_res;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= res_valid;
          out_res   <= res;
        end
      end else if (res_valid) begin
        skid_valid <= 1'b1;
        skid_res   <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_res.right, out_res.left, out_res.code};
  assign m_axis_tuser  = out_res.kind;
  assign m_axis_tlast  = out_res.last;

endmodule

`default_nettype wire

/* tb/tb_wav_header_parser_pcm_stream.sv */
// Self-checking testbench for wav_header_parser_pcm_stream: streams WAV files byte by byte,
// predicts status and stereo frame items in step, and compares them with the m_axis output.
// Depends on wavhp_pkg and the RTL top level only.
module tb_wav_header_parser_pcm_stream;
  timeunit 1ns;
  timeprecision 1ps;

  import wavhp_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int SettleCycles = 8;
  localparam int BytesPerSetting = 200;
  localparam int NumSettings = 6;
  localparam logic [CfgIndexWidth-1:0] CfgSpareIndex = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_HEADER, ST_CHUNK_HEAD, ST_FMT_BODY, ST_SKIP, ST_SAMPLES, ST_DROP
  } parse_stage_t;

  typedef struct packed {
    logic [7:0] value;
    logic       start;
  } file_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  wav_header_parser_pcm_stream dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  file_byte_t file_bytes[$];
  result_t awaited[$];
  logic [7:0] file_image[$];
  int useful_bytes = 0;
  int errors = 0;
  int cycles = 0;
  int send_gap = 0;
  int recv_stall = 0;
  logic steady = 1'b0;
  file_byte_t cur;

  // Parser mirror
  logic [31:0] want_rate;
  logic [15:0] want_bits;
  parse_stage_t stage;
  logic [4:0] pos;
  logic [31:0] tag_shift, size_shift, skip_left, data_left, sample_shift;
  logic pad_due, fmt_valid;
  logic [15:0] fmt_code, chans, bits_seen, align_seen;
  logic [31:0] rate_seen;

  function automatic void clear_parse_state();
    stage = ST_IDLE;
    pos = '0;
    tag_shift = '0;
    size_shift = '0;
    skip_left = '0;
    pad_due = 1'b0;
    fmt_code = '0;
    chans = '0;
    rate_seen = '0;
    bits_seen = '0;
    align_seen = '0;
    fmt_valid = 1'b0;
    data_left = '0;
    sample_shift = '0;
  endfunction

  function automatic logic [31:0] frame_len();
    return (chans == 16'd1) ? 32'd2 : 32'd4;
  endfunction

  function automatic status_t format_status();
    if (!fmt_valid) return STATUS_FMT_MISSING;
    if (fmt_code != FORMAT_PCM) return STATUS_UNSUPPORTED;
    if (bits_seen != want_bits) return STATUS_UNSUPPORTED;
    if (rate_seen != want_rate) return STATUS_UNSUPPORTED;
    if (chans != 16'd1 && chans != 16'd2) return STATUS_UNSUPPORTED;
    if (align_seen == 16'd0) return STATUS_ZERO_ALIGN;
    return STATUS_OK;
  endfunction

  function automatic void emit_result(input kind_t k, input status_t c,
                                      input logic [15:0] l, input logic [15:0] r,
                                      input logic fin);
    result_t res;
    res.kind = k;
    res.code = c;
    res.left = l;
    res.right = r;
    res.last = fin;
    awaited.push_back(res);
  endfunction

  function automatic void parse_wav_byte(input logic [7:0] b, input logic start);
    logic [31:0] fb, size;
    logic [15:0] left, right;
    logic hdr_ok, fin;
    status_t code;
    if (start) begin
      clear_parse_state();
      stage = ST_HEADER;
    end
    case (stage)
      ST_HEADER: begin
        tag_shift = {b, tag_shift[31:8]};
        pos++;
        if (pos == 5'd4) size_shift = tag_shift;
        if (pos >= 5'd12) begin
          hdr_ok = (size_shift == TAG_RIFF) && (tag_shift == TAG_WAVE);
          tag_shift = '0;
          size_shift = '0;
          pos = '0;
          if (!hdr_ok) begin
            stage = ST_IDLE;
            emit_result(KIND_STATUS, STATUS_NOT_WAVE, 16'd0, 16'd0, 1'b0);
          end else begin
            stage = ST_CHUNK_HEAD;
          end
        end
      end
      ST_CHUNK_HEAD: begin
        if (pos < 5'd4) tag_shift = {b, tag_shift[31:8]};
        else size_shift = {b, size_shift[31:8]};
        pos++;
        if (pos >= 5'd8) begin
          pos = '0;
          size = size_shift;
          pad_due = size[0];
          if (tag_shift == TAG_FMT) begin
            if (size < FMT_BODY_BYTES) begin
              stage = ST_IDLE;
              emit_result(KIND_STATUS, STATUS_FMT_SMALL, 16'd0, 16'd0, 1'b0);
            end else begin
              skip_left = size - FMT_BODY_BYTES;
              stage = ST_FMT_BODY;
            end
          end else if (tag_shift == TAG_DATA) begin
            code = format_status();
            pad_due = 1'b0;
            sample_shift = '0;
            if (code != STATUS_OK) begin
              stage = ST_IDLE;
            end else begin
              data_left = size;
              if (size == 0) stage = ST_IDLE;
              else if (size < frame_len()) stage = ST_DROP;
              else stage = ST_SAMPLES;
            end
            emit_result(KIND_STATUS, code, 16'd0, 16'd0, 1'b0);
          end else begin
            skip_left = size;
            stage = (skip_left == 0 && !pad_due) ? ST_CHUNK_HEAD : ST_SKIP;
          end
        end
      end
      ST_FMT_BODY: begin
        case (pos)
          5'd0: fmt_code[7:0] = b;
          5'd1: fmt_code[15:8] = b;
          5'd2: chans[7:0] = b;
          5'd3: chans[15:8] = b;
          5'd4: rate_seen = {24'd0, b};
          5'd5: rate_seen[15:8] = b;
          5'd6: rate_seen[23:16] = b;
          5'd7: rate_seen[31:24] = b;
          5'd12: align_seen[7:0] = b;
          5'd13: align_seen[15:8] = b;
          5'd14: bits_seen[7:0] = b;
          5'd15: bits_seen[15:8] = b;
          default: ;
        endcase
        // The low byte of each field clears its upper half, as a fresh capture.
        if (pos == 5'd0) fmt_code[15:8] = 8'd0;
        if (pos == 5'd2) chans[15:8] = 8'd0;
        if (pos == 5'd12) align_seen[15:8] = 8'd0;
        if (pos == 5'd14) bits_seen[15:8] = 8'd0;
        pos++;
        if (pos >= 5'd16) begin
          fmt_valid = 1'b1;
          pos = '0;
          stage = (skip_left == 0 && !pad_due) ? ST_CHUNK_HEAD : ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (skip_left != 0) skip_left--;
        else pad_due = 1'b0;
        if (skip_left == 0 && !pad_due) begin
          pos = '0;
          stage = ST_CHUNK_HEAD;
        end
      end
      ST_SAMPLES: begin
        fb = frame_len();
        sample_shift = {b, sample_shift[31:8]};
        if (data_left != 0) data_left--;
        pos++;
        if (pos >= fb) begin
          fin = (data_left < fb);
          if (fb == 32'd2) begin
            left = sample_shift[31:16];
            right = left;
          end else begin
            left = sample_shift[15:0];
            right = sample_shift[31:16];
          end
          pos = '0;
          sample_shift = '0;
          if (fin) stage = (data_left == 0) ? ST_IDLE : ST_DROP;
          emit_result(KIND_FRAME, STATUS_OK, left, right, fin);
        end
      end
      ST_DROP: begin
        if (data_left != 0) data_left--;
        if (data_left == 0) stage = ST_IDLE;
      end
      default: ;
    endcase
  endfunction

  // File image assembly
  function automatic void put8(input logic [7:0] v);
    file_image.push_back(v);
  endfunction

  function automatic void put16(input logic [15:0] v);
    put8(v[7:0]);
    put8(v[15:8]);
  endfunction

  function automatic void put32(input logic [31:0] v);
    put16(v[15:0]);
    put16(v[31:16]);
  endfunction

  function automatic void put_fill(input int n);
    for (int i = 0; i < n; i++) put8(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_fmt(input logic [31:0] size, input logic [15:0] code,
                                  input logic [15:0] ch, input logic [31:0] rate,
                                  input logic [15:0] align, input logic [15:0] smp);
    put32(TAG_FMT);
    put32(size);
    if (size < FMT_BODY_BYTES) begin
      put_fill(size);
    end else begin
      put16(code);
      put16(ch);
      put32(rate);
      put32($urandom);
      put16(align);
      put16(smp);
      put_fill(size - FMT_BODY_BYTES);
    end
    if (size[0]) put_fill(1);
  endfunction

  function automatic void put_filler_chunk();
    logic [31:0] tag, size;
    tag = $urandom;
    if (tag == TAG_FMT || tag == TAG_DATA) tag = TAG_WAVE;
    size = $urandom_range(0, 7);
    put32(tag);
    put32(size);
    put_fill(size);
    if (size[0]) put_fill(1);
  endfunction

  function automatic void flush_file(input int n);
    file_byte_t fbyte;
    for (int i = 0; i < n; i++) begin
      fbyte.value = file_image[i];
      fbyte.start = (i == 0);
      file_bytes.push_back(fbyte);
    end
    useful_bytes += n;
    file_image.delete();
  endfunction

  function automatic void push_stray(input int n);
    file_byte_t fbyte;
    for (int i = 0; i < n; i++) begin
      fbyte.value = 8'($urandom_range(0, 255));
      fbyte.start = 1'b0;
      file_bytes.push_back(fbyte);
    end
  endfunction

  // Mostly well-formed files; about half carry one flaw chosen at random.
  function automatic void queue_random_file();
    int flaw, k, cut;
    logic [15:0] ch, code, smp, align;
    logic [31:0] rate, dsize;
    flaw = $urandom_range(0, 15);
    ch = 16'($urandom_range(1, 2));
    code = FORMAT_PCM;
    smp = want_bits;
    rate = want_rate;
    align = ch * 16'd2;
    case (flaw)
      10: code = 16'($urandom);
      11: smp = 16'($urandom);
      12: rate = $urandom;
      13: ch = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(3, 65535));
      14: align = 16'd0;
      default: ;
    endcase
    put32(TAG_RIFF);
    put32($urandom);
    put32(TAG_WAVE);
    if (flaw == 7) begin
      k = $urandom_range(0, 7);
      if (k >= 4) k += 4;
      file_image[k] = file_image[k] ^ (8'd1 << $urandom_range(0, 7));
    end
    if ($urandom_range(0, 2) == 0) put_filler_chunk();
    if (flaw != 9) begin
      // An earlier format chunk that the later one must override.
      if ($urandom_range(0, 4) == 0)
        put_fmt(32'd16, 16'($urandom), 16'($urandom), $urandom, 16'($urandom),
                16'($urandom));
      if (flaw == 8) put_fmt($urandom_range(0, 15), code, ch, rate, align, smp);
      else put_fmt($urandom_range(0, 1) ? 32'd16 : 32'($urandom_range(17, 21)),
                   code, ch, rate, align, smp);
    end
    if ($urandom_range(0, 3) == 0) put_filler_chunk();
    if (flaw == 15) begin
      // A chunk far longer than the file, cut short by the next file.
      put32($urandom_range(0, 1) ? TAG_DATA : 32'h6B6E_756A);
      put32(32'hFFFF_0000 | 32'($urandom_range(0, 65535)));
      put_fill($urandom_range(6, 40));
    end else begin
      dsize = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 14);
      put32(TAG_DATA);
      put32(dsize);
      put_fill(dsize);
      if ($urandom_range(0, 3) == 0) put_fill($urandom_range(1, 3));
    end
    cut = file_image.size();
    if ($urandom_range(0, 19) == 0) cut = $urandom_range(1, file_image.size());
    flush_file(cut);
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [39:0] want_v,
                                 input logic [39:0] got_v);
    errors++;
    if (errors <= 50)
      $display("mismatch on %s: expected %0h, got %0h", what, want_v, got_v);
  endtask

  // Sender: one item per handshake, with random gaps between items.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) parse_wav_byte(s_axis_tdata, s_axis_tuser);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (file_bytes.size() != 0) begin
          cur = file_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= cur.value;
          s_axis_tuser <= cur.start;
          if (!steady && $urandom_range(0, 3) == 0) send_gap = gap_len();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted item against the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited.size() == 0) begin
          report_mismatch("unexpected item", 40'd0,
                          {m_axis_tdata[38:0], m_axis_tuser ^ m_axis_tlast});
        end else begin
          want = awaited.pop_front();
          if (m_axis_tuser !== want.kind)
            report_mismatch("result kind", 40'(want.kind), 40'(m_axis_tuser));
          if (m_axis_tdata[2:0] !== want.code)
            report_mismatch("status code", 40'(want.code), 40'(m_axis_tdata[2:0]));
          if (m_axis_tdata[18:3] !== want.left)
            report_mismatch("left sample", 40'(want.left), 40'(m_axis_tdata[18:3]));
          if (m_axis_tdata[34:19] !== want.right)
            report_mismatch("right sample", 40'(want.right), 40'(m_axis_tdata[34:19]));
          if (m_axis_tlast !== want.last)
            report_mismatch("last frame", 40'(want.last), 40'(m_axis_tlast));
          if (m_axis_tdata[39:35] !== 5'd0)
            report_mismatch("unused data bits", 40'd0, 40'(m_axis_tdata[39:35]));
        end
      end
      if (recv_stall != 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) recv_stall = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Sampled on the falling edge, clear of the clocked blocks.
  task automatic wait_quiet();
    do @(negedge clk);
    while (file_bytes.size() != 0 || s_axis_tvalid || awaited.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SAMPLE_RATE) want_rate = val;
    else if (idx == CFG_SAMPLE_BITS) want_bits = val[15:0];
  endtask

  initial begin
    int budget;
    want_rate = RESET_SAMPLE_RATE;
    want_bits = RESET_SAMPLE_BITS;
    clear_parse_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Bytes before any file are ignored; then a broken WAVE tag.
    push_stray(2);
    put32(TAG_RIFF);
    put32(32'd0);
    put32(TAG_WAVE ^ 32'h0100_0000);
    flush_file(12);
    // Mono file with extreme samples and one odd trailing byte that is dropped.
    put32(TAG_RIFF);
    put32(32'd41);
    put32(TAG_WAVE);
    put_fmt(32'd16, FORMAT_PCM, 16'd1, RESET_SAMPLE_RATE, 16'd2, RESET_SAMPLE_BITS);
    put32(TAG_DATA);
    put32(32'd5);
    put16(16'h8000);
    put16(16'h7FFF);
    put8(8'h5A);
    flush_file(file_image.size());
    wait_quiet();

    for (int setting = 0; setting < NumSettings; setting++) begin
      case (setting)
        1: begin
          write_reg(CFG_SAMPLE_RATE, 32'd1);
          write_reg(CFG_SAMPLE_BITS, 32'd1);
        end
        2: begin
          write_reg(CFG_SAMPLE_RATE, 32'hFFFF_FFFF);
          write_reg(CFG_SAMPLE_BITS, 32'h0000_FFFF);
          write_reg(CfgSpareIndex, $urandom);
        end
        3: begin
          write_reg(CFG_SAMPLE_RATE, 32'd44100);
          write_reg(CFG_SAMPLE_BITS, 32'd16);
        end
        4: begin
          write_reg(CFG_SAMPLE_RATE, $urandom);
          write_reg(CFG_SAMPLE_BITS, $urandom);
        end
        5: begin
          write_reg(CFG_SAMPLE_RATE, 32'd16000);
          write_reg(CFG_SAMPLE_BITS, 32'd8);
        end
        default: ;
      endcase
      steady = (setting == 3);
      budget = useful_bytes + BytesPerSetting;
      while (useful_bytes < budget) begin
        if ($urandom_range(0, 7) == 0) push_stray($urandom_range(1, 3));
        queue_random_file();
      end
      wait_quiet();
    end

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
